// ===== src/idc_pkg.sv =====
`timescale 1ns / 1ps

package idc_pkg;

   localparam int SIDE_MAX    = 32;
   localparam int ADDR_W      = $clog2(SIDE_MAX);
   localparam int SIDE_W      = ADDR_W + 1;
   localparam int SAMPLE_W    = 8;
   localparam int CMD_W       = 2;
   localparam int LOG2_W      = 3;
   localparam int LOG2_MIN    = 2;
   localparam int LOG2_MAX    = (ADDR_W < 5) ? ADDR_W : 5;
   localparam int FILT_LIMIT  = 32;
   localparam int ACC_W       = $clog2(2 * SIDE_MAX * 255 + SIDE_MAX + 1);
   localparam int STEP_W      = $clog2(2 * SIDE_MAX + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = LOG2_W;

   localparam logic SIDE_TOP  = 1'b0;
   localparam logic SIDE_LEFT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_SIZE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_FILTER = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_DC   = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_FILT,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      KIND_HOLD,
      KIND_MEAN,
      KIND_FILT
   } kind_type;

   typedef enum logic [1:0] {
      ALU_HOLD,
      ALU_LOAD,
      ALU_ADD
   } alu_op_type;

   typedef struct packed {
      logic [LOG2_W-1:0] log2_size;
      logic              edge_filter;
   } cfg_type;

   typedef struct packed {
      logic                we;
      logic                we_side;
      logic [ADDR_W-1:0]   waddr;
      logic [SAMPLE_W-1:0] wdata;
      logic [ADDR_W-1:0]   raddr_top;
      logic [ADDR_W-1:0]   raddr_left;
   } store_ctl_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ACC_W-1:0] operand;
   } alu_ctl_type;

endpackage

// ===== src/idc_if.sv =====
`timescale 1ns / 1ps

interface idc_req_if
   import idc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic                side;
   logic [ADDR_W-1:0]   offset;
   logic [SAMPLE_W-1:0] sample;
   logic [ADDR_W-1:0]   col;
   logic [ADDR_W-1:0]   row;

   modport source (output valid, cmd, side, offset, sample, col, row, input ready);
   modport sink (input valid, cmd, side, offset, sample, col, row, output ready);
endinterface

interface idc_rsp_if
   import idc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] value;

   modport source (output valid, value, input ready);
   modport sink (input valid, value, output ready);
endinterface

// ===== src/idc_store.sv =====
`timescale 1ns / 1ps

module idc_store
   import idc_pkg::*;
(
   input  logic                clock,
   input  store_ctl_type       ctl,
   output logic [SAMPLE_W-1:0] top_q,
   output logic [SAMPLE_W-1:0] left_q
);

   logic [SAMPLE_W-1:0] top_mem_ff  [SIDE_MAX];
   logic [SAMPLE_W-1:0] left_mem_ff [SIDE_MAX];
   logic [SAMPLE_W-1:0] top_q_ff;
   logic [SAMPLE_W-1:0] left_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.we && ctl.we_side == SIDE_TOP) begin
         top_mem_ff[ctl.waddr] <= ctl.wdata;
      end
      top_q_ff <= top_mem_ff[ctl.raddr_top];
   end

   always_ff @(posedge clock) begin
      if (ctl.we && ctl.we_side == SIDE_LEFT) begin
         left_mem_ff[ctl.waddr] <= ctl.wdata;
      end
      left_q_ff <= left_mem_ff[ctl.raddr_left];
   end

   assign top_q  = top_q_ff;
   assign left_q = left_q_ff;

endmodule

// ===== src/idc_alu.sv =====
`timescale 1ns / 1ps

module idc_alu
   import idc_pkg::*;
(
   input  logic             clock,
   input  alu_ctl_type      ctl,
   output logic [ACC_W-1:0] acc
);

   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;

   always_comb begin
      case (ctl.op)
         ALU_LOAD: acc_in = ctl.operand;
         ALU_ADD:  acc_in = acc_ff + ctl.operand;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== src/idc_seq.sv =====
`timescale 1ns / 1ps

module idc_seq
   import idc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   idc_req_if.sink             req,
   idc_rsp_if.source           rsp,
   input  logic [SAMPLE_W-1:0] top_q,
   input  logic [SAMPLE_W-1:0] left_q,
   input  logic [ACC_W-1:0]    acc,
   output store_ctl_type       store_ctl,
   output alu_ctl_type         alu_ctl
);

   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ADDR_W-1:0]   x_ff, x_in;
   logic [ADDR_W-1:0]   y_ff, y_in;
   logic                corner_ff, corner_in;
   logic                row0_ff, row0_in;
   logic [SAMPLE_W-1:0] dc_ff, dc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [LOG2_W-1:0]   k;
   logic [SIDE_W-1:0]   n;
   logic [STEP_W-1:0]   two_n;
   logic [ADDR_W-1:0]   mask;
   logic [ADDR_W-1:0]   x;
   logic [ADDR_W-1:0]   y;
   logic                filt_on;
   logic [SAMPLE_W-1:0] mean;
   logic [SAMPLE_W-1:0] filt;

   always_comb begin
      if (cfg.log2_size < LOG2_W'(LOG2_MIN)) begin
         k = LOG2_W'(LOG2_MIN);
      end else if (cfg.log2_size > LOG2_W'(LOG2_MAX)) begin
         k = LOG2_W'(LOG2_MAX);
      end else begin
         k = cfg.log2_size;
      end
   end

   assign n       = SIDE_W'(1) << k;
   assign two_n   = STEP_W'(n) << 1;
   assign mask    = ADDR_W'(n - SIDE_W'(1));
   assign x       = req.col & mask;
   assign y       = req.row & mask;
   assign filt_on = cfg.edge_filter && (n < SIDE_W'(FILT_LIMIT));
   assign mean    = SAMPLE_W'(acc >> (k + LOG2_W'(1)));
   assign filt    = SAMPLE_W'(acc >> 2);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dc_ff        <= dc_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      step_ff      <= step_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      corner_ff    <= corner_in;
      row0_ff      <= row0_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      corner_in    = corner_ff;
      row0_in      = row0_ff;
      dc_in        = dc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;

      store_ctl.we         = 1'b0;
      store_ctl.we_side    = req.side;
      store_ctl.waddr      = req.offset;
      store_ctl.wdata      = req.sample;
      store_ctl.raddr_top  = (state_ff == ST_SUM) ? step_ff[ADDR_W:1] : x_ff;
      store_ctl.raddr_left = (state_ff == ST_SUM) ? step_ff[ADDR_W:1] : y_ff;

      alu_ctl.op      = ALU_HOLD;
      alu_ctl.operand = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               case (req.cmd)
                  CMD_LOAD: begin
                     store_ctl.we = 1'b1;
                  end
                  CMD_DC: begin
                     alu_ctl.op      = ALU_LOAD;
                     alu_ctl.operand = ACC_W'(n);
                     step_in         = '0;
                     kind_in         = KIND_MEAN;
                     state_in        = ST_SUM;
                  end
                  CMD_READ: begin
                     x_in      = x;
                     y_in      = y;
                     corner_in = (x == '0) && (y == '0);
                     row0_in   = (y == '0);
                     step_in   = '0;
                     if (filt_on && (x == '0 || y == '0)) begin
                        kind_in  = KIND_FILT;
                        state_in = ST_FILT;
                     end else begin
                        kind_in  = KIND_HOLD;
                        state_in = ST_FIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SUM: begin
            if (step_ff != '0) begin
               alu_ctl.op      = ALU_ADD;
               alu_ctl.operand = step_ff[0] ? ACC_W'(top_q) : ACC_W'(left_q);
            end
            if (step_ff == two_n) begin
               state_in = ST_FIN;
            end
            step_in = step_ff + STEP_W'(1);
         end
         ST_FILT: begin
            case (step_ff[1:0])
               2'd0: begin
                  alu_ctl.op      = ALU_LOAD;
                  alu_ctl.operand = ACC_W'(2);
               end
               2'd1: begin
                  alu_ctl.op      = ALU_ADD;
                  alu_ctl.operand = ACC_W'({dc_ff, 1'b0});
               end
               2'd2: begin
                  alu_ctl.op      = ALU_ADD;
                  alu_ctl.operand = corner_ff ? ACC_W'(top_q) : ACC_W'(dc_ff);
               end
               default: begin
                  alu_ctl.op = ALU_ADD;
                  if (corner_ff || !row0_ff) begin
                     alu_ctl.operand = ACC_W'(left_q);
                  end else begin
                     alu_ctl.operand = ACC_W'(top_q);
                  end
                  state_in = ST_FIN;
               end
            endcase
            step_in = step_ff + STEP_W'(1);
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               case (kind_ff)
                  KIND_MEAN: begin
                     rsp_value_in = mean;
                     dc_in        = mean;
                  end
                  KIND_FILT: rsp_value_in = filt;
                  default:   rsp_value_in = dc_ff;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_sum_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && step_ff == two_n) |=> (state_ff == ST_FIN))
      else $error("sum walk did not finish after the last sample");

   a_dc_start: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.cmd == CMD_DC) |=> (state_ff == ST_SUM && step_ff == '0))
      else $error("compute request did not start the sum walk");

   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && (!rsp_valid_ff || rsp.ready)) |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_filt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && kind_ff == KIND_FILT) |-> (acc[ACC_W-1:SAMPLE_W+2] == '0))
      else $error("smoothed pixel exceeds sample range");
`endif

endmodule

// ===== src/intra_dc_predictor.sv =====
`timescale 1ns / 1ps

// Intra DC predictor for square blocks of 4 to 32 samples per side. A load request writes one top
// or left neighbour and the block stays ready for the next request. A compute request walks
// both neighbour stores through a single accumulator, one sample per cycle. A read of a pixel in
// the smoothed first row or column has the same accumulator add the terms one at a time. The block
// takes no request while a command is at work. Neighbour stores are not cleared at reset and a
// sample must be loaded before it is used; the DC value resets to zero.
module intra_dc_predictor
   import idc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   idc_req_if.sink               req_chan,
   idc_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type             cfg_ff, cfg_in;
   store_ctl_type       store_ctl;
   alu_ctl_type         alu_ctl;
   logic [SAMPLE_W-1:0] top_q;
   logic [SAMPLE_W-1:0] left_q;
   logic [ACC_W-1:0]    acc;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOG2_SIZE:   cfg_in.log2_size   = csr_wdata;
            CSR_EDGE_FILTER: cfg_in.edge_filter = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log2_size   <= LOG2_W'(LOG2_MIN);
         cfg_ff.edge_filter <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   idc_store u_store (
      .clock  (clock),
      .ctl    (store_ctl),
      .top_q  (top_q),
      .left_q (left_q)
   );

   idc_alu u_alu (
      .clock (clock),
      .ctl   (alu_ctl),
      .acc   (acc)
   );

   idc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .top_q     (top_q),
      .left_q    (left_q),
      .acc       (acc),
      .store_ctl (store_ctl),
      .alu_ctl   (alu_ctl)
   );

endmodule

// ===== verif/intra_dc_predictor_tb.sv =====
`timescale 1ns / 1ps

module intra_dc_predictor_tb;
   import idc_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int NO_VALUE      = -1;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 170;
   localparam int HOLD_SEGMENT  = 8;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic                side;
      logic [ADDR_W-1:0]   offset;
      logic [SAMPLE_W-1:0] sample;
      logic [ADDR_W-1:0]   col;
      logic [ADDR_W-1:0]   row;
   } dc_request_type;

   typedef enum {STEP_REQ, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type         kind;
      dc_request_type        req;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      int                    want;
   } plan_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   idc_req_if req_chan ();
   idc_rsp_if rsp_chan ();

   intra_dc_predictor dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [SAMPLE_W-1:0] top_nb [SIDE_MAX];
   logic [SAMPLE_W-1:0] left_nb [SIDE_MAX];
   bit                  top_seen [SIDE_MAX];
   bit                  left_seen [SIDE_MAX];
   logic [SAMPLE_W-1:0] dc_held;
   logic [LOG2_W-1:0]   size_reg;
   logic                filter_reg;
   logic [SAMPLE_W-1:0] pending_pixels [$];

   int   bad_values   = 0;
   int   req_idle_pct = 26;
   int   rsp_idle_pct = 58;
   int   quiet_cycles = 0;
   int   hold_left    = 0;
   bit   hold_started = 1'b0;
   logic hold_go;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int block_log2();
      int k;
      k = size_reg;
      if (k < LOG2_MIN) k = LOG2_MIN;
      if (k > LOG2_MAX) k = LOG2_MAX;
      while ((1 << k) > SIDE_MAX) k--;
      return k;
   endfunction

   function automatic bit neighbours_ready(dc_request_type req);
      int n;
      int x;
      int y;
      n = 1 << block_log2();
      if (req.cmd == CMD_DC) begin
         for (int i = 0; i < n; i++)
            if (!top_seen[i] || !left_seen[i]) return 1'b0;
      end else if (req.cmd == CMD_READ && filter_reg && n < FILT_LIMIT) begin
         x = req.col & (n - 1);
         y = req.row & (n - 1);
         if (y == 0 && !top_seen[x]) return 1'b0;
         if (x == 0 && !left_seen[y]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void dc_pixel_update(dc_request_type req, output bit has_val,
                                           output logic [SAMPLE_W-1:0] val);
      int k;
      int n;
      int sum;
      int x;
      int y;
      int v;
      k = block_log2();
      n = 1 << k;
      has_val = 1'b0;
      val = '0;
      case (req.cmd)
         CMD_LOAD: begin
            if (req.side == SIDE_LEFT) begin
               left_nb[req.offset] = req.sample;
               left_seen[req.offset] = 1'b1;
            end else begin
               top_nb[req.offset] = req.sample;
               top_seen[req.offset] = 1'b1;
            end
         end
         CMD_DC: begin
            sum = n;
            for (int i = 0; i < n; i++) sum += top_nb[i] + left_nb[i];
            dc_held = SAMPLE_W'(sum >> (k + 1));
            has_val = 1'b1;
            val = dc_held;
         end
         CMD_READ: begin
            x = req.col & (n - 1);
            y = req.row & (n - 1);
            v = dc_held;
            if (filter_reg && n < FILT_LIMIT) begin
               if (x == 0 && y == 0)
                  v = (left_nb[0] + 2 * dc_held + top_nb[0] + 2) >> 2;
               else if (y == 0)
                  v = (top_nb[x] + 3 * dc_held + 2) >> 2;
               else if (x == 0)
                  v = (left_nb[y] + 3 * dc_held + 2) >> 2;
            end
            has_val = 1'b1;
            val = v[SAMPLE_W-1:0];
         end
         default: ;
      endcase
   endfunction

   function automatic dc_request_type random_request();
      dc_request_type req;
      req.cmd    = CMD_W'($urandom_range(0, 3));
      req.side   = 1'($urandom_range(0, 1));
      req.offset = ADDR_W'($urandom_range(0, SIDE_MAX - 1));
      req.sample = SAMPLE_W'($urandom_range(0, 255));
      req.col    = ADDR_W'($urandom_range(0, SIDE_MAX - 1));
      req.row    = ADDR_W'($urandom_range(0, SIDE_MAX - 1));
      return req;
   endfunction

   function automatic plan_step_type req_step(logic [CMD_W-1:0] cmd, logic side, int offset,
                                              int sample, int col, int row, int want);
      plan_step_type st;
      st.kind       = STEP_REQ;
      st.req.cmd    = cmd;
      st.req.side   = side;
      st.req.offset = ADDR_W'(offset);
      st.req.sample = SAMPLE_W'(sample);
      st.req.col    = ADDR_W'(col);
      st.req.row    = ADDR_W'(row);
      st.csr_idx    = CSR_LOG2_SIZE;
      st.csr_val    = '0;
      st.want       = want;
      return st;
   endfunction

   function automatic plan_step_type csr_step(logic [CSR_IDX_W-1:0] idx, int val);
      plan_step_type st;
      st = req_step(CMD_LOAD, SIDE_TOP, 0, 0, 0, 0, NO_VALUE);
      st.kind    = STEP_CSR;
      st.csr_idx = idx;
      st.csr_val = CSR_DATA_W'(val);
      return st;
   endfunction

   task automatic push_request(dc_request_type req, int want);
      bit                  has_val;
      logic [SAMPLE_W-1:0] val;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.cmd    <= req.cmd;
      req_chan.side   <= req.side;
      req_chan.offset <= req.offset;
      req_chan.sample <= req.sample;
      req_chan.col    <= req.col;
      req_chan.row    <= req.row;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      dc_pixel_update(req, has_val, val);
      if (has_val)
         pending_pixels.push_back(want == NO_VALUE ? val : want[SAMPLE_W-1:0]);
   endtask

   task automatic offer(dc_request_type req, inout int count);
      if (!neighbours_ready(req)) return;
      push_request(req, NO_VALUE);
      if (req.cmd != CMD_UNUSED) count++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LOG2_SIZE) size_reg = val;
      else filter_reg = val[0];
      @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      logic [SAMPLE_W-1:0] oldest;
      if (hold_go && !hold_started) begin
         hold_started = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pixels.size() == 0) begin
            bad_values++;
            $display("%0t: unexpected value, expected none, got %0d", $time, rsp_chan.value);
         end else begin
            oldest = pending_pixels.pop_front();
            if (rsp_chan.value !== oldest) begin
               bad_values++;
               $display("%0t: value mismatch, expected %0d, got %0d",
                        $time, oldest, rsp_chan.value);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d values outstanding",
                  $time, quiet_cycles, pending_pixels.size());
         $display("intra_dc_predictor_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      plan_step_type  plan [$];
      dc_request_type req;
      int             order [$];
      int             n;
      int             count;
      int             pick;
      int             swap;

      csr_we          = 1'b0;
      csr_index       = CSR_LOG2_SIZE;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.cmd    = CMD_LOAD;
      req_chan.side   = SIDE_TOP;
      req_chan.offset = '0;
      req_chan.sample = '0;
      req_chan.col    = '0;
      req_chan.row    = '0;
      hold_go         = 1'b0;
      size_reg        = LOG2_W'(LOG2_MIN);
      filter_reg      = 1'b0;
      dc_held         = '0;

      // read with nothing computed yet, then the unused command
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 0, 0, 0));
      plan.push_back(req_step(CMD_UNUSED, SIDE_LEFT, 31, 255, 31, 31, NO_VALUE));
      for (int i = 0; i < 4; i++) plan.push_back(req_step(CMD_LOAD, SIDE_TOP, i, 255, 0, 0, NO_VALUE));
      for (int i = 0; i < 4; i++) plan.push_back(req_step(CMD_LOAD, SIDE_LEFT, i, 255, 0, 0, NO_VALUE));
      plan.push_back(req_step(CMD_DC, SIDE_TOP, 0, 0, 0, 0, 255));
      plan.push_back(csr_step(CSR_EDGE_FILTER, 1));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 0, 0, 255));
      plan.push_back(req_step(CMD_LOAD, SIDE_LEFT, 0, 0, 0, 0, NO_VALUE));
      plan.push_back(req_step(CMD_LOAD, SIDE_TOP, 1, 0, 0, 0, NO_VALUE));
      plan.push_back(req_step(CMD_DC, SIDE_TOP, 0, 0, 0, 0, NO_VALUE));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 0, 0, NO_VALUE));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 31, 0, NO_VALUE));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 1, 4, NO_VALUE));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 0, 31, NO_VALUE));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 2, 2, NO_VALUE));
      // oversized setting: side 32, smoothing off
      plan.push_back(csr_step(CSR_LOG2_SIZE, 7));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 0, 0, NO_VALUE));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 31, 31, NO_VALUE));
      plan.push_back(csr_step(CSR_LOG2_SIZE, 0));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 0, 0, NO_VALUE));
      plan.push_back(csr_step(CSR_LOG2_SIZE, 1));
      plan.push_back(csr_step(CSR_EDGE_FILTER, 0));
      plan.push_back(req_step(CMD_READ, SIDE_TOP, 0, 0, 0, 1, NO_VALUE));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_CSR) begin
            settle();
            write_csr(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            push_request(plan[i].req, plan[i].want);
         end
      end

      for (int s = 0; s < SEGMENTS; s++) begin
         settle();
         if (s < 4) begin
            req_idle_pct = 26;
            rsp_idle_pct = 58;
         end else if (s < HOLD_SEGMENT) begin
            req_idle_pct = 58;
            rsp_idle_pct = 26;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_csr(CSR_LOG2_SIZE, CSR_DATA_W'(s % 8));
         write_csr(CSR_EDGE_FILTER, CSR_DATA_W'((s / 3) % 2));
         // stall the result side while requests keep coming
         if (s == HOLD_SEGMENT) hold_go <= 1'b1;
         n = 1 << block_log2();
         count = 0;
         while (count < SEGMENT_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               // reload every neighbour in shuffled order, compute, then read pixels
               order.delete();
               for (int i = 0; i < 2 * n; i++) order.push_back(i);
               for (int j = 2 * n - 1; j > 0; j--) begin
                  pick = $urandom_range(0, j);
                  swap = order[j];
                  order[j] = order[pick];
                  order[pick] = swap;
               end
               foreach (order[j]) begin
                  req = random_request();
                  req.cmd = CMD_LOAD;
                  req.side = (order[j] >= n) ? SIDE_LEFT : SIDE_TOP;
                  req.offset = ADDR_W'(order[j] % n);
                  if ($urandom_range(0, 7) == 0)
                     req.sample = $urandom_range(0, 1) ? 8'hff : 8'h00;
                  offer(req, count);
               end
               req = random_request();
               req.cmd = CMD_DC;
               offer(req, count);
               repeat ($urandom_range(4, 24)) begin
                  req = random_request();
                  if ($urandom_range(0, 9) != 0) begin
                     req.cmd = CMD_READ;
                     case ($urandom_range(0, 3))
                        0: req.row = ADDR_W'(($urandom_range(0, SIDE_MAX - 1) / n) * n);
                        1: req.col = ADDR_W'(($urandom_range(0, SIDE_MAX - 1) / n) * n);
                        2: begin
                           req.row = ADDR_W'(($urandom_range(0, SIDE_MAX - 1) / n) * n);
                           req.col = ADDR_W'(($urandom_range(0, SIDE_MAX - 1) / n) * n);
                        end
                        default: ;
                     endcase
                  end
                  offer(req, count);
               end
            end else begin
               repeat ($urandom_range(1, 8)) offer(random_request(), count);
            end
         end
      end

      settle();
      if (bad_values == 0)
         $display("intra_dc_predictor_tb: PASS");
      else
         $display("intra_dc_predictor_tb: FAIL");
      $finish;
   end

endmodule
